FILE: design/binomial_option_pricer_macros.svh
// Assertion macros used by the binomial option pricer checker.
`ifndef BINOMIAL_OPTION_PRICER_MACROS_SVH
`define BINOMIAL_OPTION_PRICER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BOP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("binomial_option_pricer port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BOP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("binomial_option_pricer port check failed");

`endif

FILE: design/bop_pkg.sv
// Shared widths, defaults and register indexes of the binomial option pricer.
package bop_pkg;

    localparam int PRICE_W   = 32;
    localparam int MOVE_W    = 16;
    localparam int DISC_W    = 17;
    localparam int PERIOD_W  = 6;
    localparam int DELTA_W   = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 56;

    localparam int MAX_PERIODS_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [MOVE_W-1:0]   MOVE_RST   = 16'd6554;
    localparam logic [DISC_W-1:0]   DISC_RST   = 17'd65536;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 6'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOVE_FRACTION   = 2'd0,
        REG_DISCOUNT_FACTOR = 2'd1,
        REG_PERIOD_COUNT    = 2'd2
    } cfg_reg_t;

endpackage

FILE: design/bop_mul.sv
// Shared signed multiplier with a registered product.
module bop_mul #(
    parameter int A_W = 34,
    parameter int B_W = 18
) (
    input  logic                    aclk,
    input  logic signed [A_W-1:0]   mul_a,
    input  logic signed [B_W-1:0]   mul_b,
    output logic signed [A_W+B_W-1:0] prod_reg
);

    // One product per cycle, registered in the cycle after its operands
    always_ff @(posedge aclk) begin
        prod_reg <= (A_W+B_W)'(mul_a) * (A_W+B_W)'(mul_b);
    end

endmodule

FILE: design/bop_div.sv
// Restoring divider, one quotient bit per cycle.
module bop_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done_reg,
    output logic [DVD_W-1:0] quo_reg
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W:0]   rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        rem_sh = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
        fits   = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/binomial_option_pricer.sv
// One word is priced at a time: the leaf payoffs are set up first, then each lattice
// node is updated level by level. The shared multiplier carries every node update, and
// the serial divider computes each node's delta when the up spot exceeds the down spot.
// A new word is taken as soon as the sequencer is idle. Reset (aresetn low, synchronous)
// restores the configuration registers, the sequencer state and the output valid flag.
module binomial_option_pricer #(
    parameter int MAX_PERIODS = bop_pkg::MAX_PERIODS_DEF,
    parameter int FRAC_BITS   = bop_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bop_pkg::S_DATA_W-1:0]    s_tdata,   // spot_price, strike_price
    input  logic [0:0]                      s_tuser,   // is_put
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bop_pkg::M_DATA_W-1:0]    m_tdata,   // option_value, hedge_delta, zero pad
    output logic [0:0]                      m_tuser,   // saturated
    input  logic                            cfg_wr_en,
    input  logic [bop_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bop_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

    localparam int PW    = bop_pkg::PRICE_W;
    localparam int IDX_W = $clog2(MAX_PERIODS + 1);
    localparam int FAC_W = FRAC_BITS + 1;
    localparam int DLT_W = FRAC_BITS + 2;
    localparam int A_W   = PW + 2;
    localparam int B_W   = (DLT_W > bop_pkg::DISC_W + 1) ? DLT_W : bop_pkg::DISC_W + 1;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = P_W + 1;
    localparam int DVD_W = PW + FRAC_BITS;
    localparam logic [31:0]      UNIT_M1 = 32'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [FAC_W-1:0] UNIT    = FAC_W'(64'd1 << FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_LEAF_INIT, S_CHAIN, S_CHAIN_TAKE, S_LEAF_WR, S_NODE_INIT,
        S_SU_MUL, S_SU_TAKE, S_SD_MUL, S_SD_TAKE, S_RD_VU, S_RD_VD, S_RD_DONE,
        S_DIV, S_DIV_WAIT, S_A_MUL, S_A_TAKE, S_B_MUL, S_B_TAKE, S_T_MUL,
        S_T_TAKE, S_OUT
    } state_t;

    // Configuration registers
    logic [bop_pkg::MOVE_W-1:0]   move_reg;
    logic [bop_pkg::DISC_W-1:0]   disc_cfg_reg;
    logic [bop_pkg::PERIOD_W-1:0] period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_reg     <= bop_pkg::MOVE_RST;
            disc_cfg_reg <= bop_pkg::DISC_RST;
            period_reg   <= bop_pkg::PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bop_pkg::REG_MOVE_FRACTION:
                    move_reg <= cfg_wdata[bop_pkg::MOVE_W-1:0];
                bop_pkg::REG_DISCOUNT_FACTOR:
                    disc_cfg_reg <= cfg_wdata[bop_pkg::DISC_W-1:0];
                bop_pkg::REG_PERIOD_COUNT:
                    period_reg <= cfg_wdata[bop_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state
    state_t state_reg;
    logic [PW-1:0]     s0_reg, k_reg, x_reg, su_reg, sd_reg, vu_reg, vd_reg, last_val_reg;
    logic              put_reg, clamp_reg, dv_neg_reg;
    logic [FAC_W-1:0]  up_reg, dn_reg;
    logic [bop_pkg::DISC_W-1:0] disc_reg;
    logic [IDX_W-1:0]  n_reg, lvl_reg, i_reg, downs_reg, ups_reg;
    logic              leaf_reg;
    logic signed [DLT_W-1:0] delta_reg;
    logic signed [P_W-1:0]   a_reg;
    logic signed [A_W-1:0]   bq_reg;

    // Output register
    logic              m_valid_reg;
    logic [PW-1:0]     m_val_reg;
    logic signed [bop_pkg::DELTA_W-1:0] m_delta_reg;
    logic              m_sat_reg;

    // Shared multiplier and divider
    logic signed [A_W-1:0] mul_a;
    logic signed [B_W-1:0] mul_b;
    logic signed [P_W-1:0] prod_reg;
    logic                  div_start, div_done;
    logic [DVD_W-1:0]      div_dvd, div_quo;
    logic [PW-1:0]         div_dvs;

    bop_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    bop_div #(.DVD_W(DVD_W), .DVS_W(PW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done_reg (div_done),
        .quo_reg  (div_quo)
    );

    // Value lattice memory, one entry per node of a level
    logic [PW-1:0]    val_mem [0:MAX_PERIODS];
    logic [PW-1:0]    rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [PW-1:0]    wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            val_mem[i_reg] <= wr_data;
        end
        rd_data_reg <= val_mem[rd_addr];
    end

    // Datapath around the shared units
    logic              scl_clamp;
    logic [PW-1:0]     scl_val, payoff;
    logic signed [PW:0] dv;
    logic [PW-1:0]     dv_abs;
    logic [FAC_W-1:0]  mag;
    logic              mag_clamp;
    logic signed [DLT_W-1:0] div_delta;
    logic signed [P_W:0]   vd_sh, b_full;
    logic signed [ACC_W-1:0] tot, tq;
    logic [PW-1:0]     node_val;
    logic              node_clamp;
    logic [FRAC_BITS-1:0] v_eff;
    logic [IDX_W-1:0]  n_eff;

    always_comb begin
        // Request setup: limit v below one unit and N to the lattice depth
        v_eff = (32'(move_reg) > UNIT_M1) ? FRAC_BITS'(UNIT_M1) : FRAC_BITS'(move_reg);
        n_eff = (int'(period_reg) > MAX_PERIODS) ? IDX_W'(MAX_PERIODS) : IDX_W'(period_reg);

        // Floored price scaling with clamp
        scl_clamp = (prod_reg[P_W-1:FRAC_BITS+PW] != '0);
        scl_val   = scl_clamp ? '1 : prod_reg[FRAC_BITS+PW-1:FRAC_BITS];

        payoff = put_reg ? ((k_reg > x_reg) ? k_reg - x_reg : '0)
                         : ((x_reg > k_reg) ? x_reg - k_reg : '0);

        // Delta numerator and quotient
        dv      = $signed({1'b0, vu_reg}) - $signed({1'b0, vd_reg});
        dv_abs  = dv[PW] ? PW'(-dv) : PW'(dv);
        div_dvd = {dv_abs, {FRAC_BITS{1'b0}}};
        div_dvs = su_reg - sd_reg;
        mag_clamp = (div_quo > DVD_W'(UNIT));
        mag       = mag_clamp ? UNIT : FAC_W'(div_quo);
        div_delta = dv_neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        // (vd << F) - sd*delta
        vd_sh  = $signed((P_W+1)'({vd_reg, {FRAC_BITS{1'b0}}}));
        b_full = vd_sh - (P_W+1)'(prod_reg);

        // s*delta + floor(b)*disc, floored and clamped
        tot = ACC_W'(a_reg) + ACC_W'(prod_reg);
        tq  = tot >>> FRAC_BITS;
        node_clamp = tq[ACC_W-1] || (tq[ACC_W-1:PW] != '0);
        node_val   = tq[ACC_W-1] ? '0 : (node_clamp ? '1 : tq[PW-1:0]);

        // Multiplier operand select
        mul_a = $signed({2'b00, x_reg});
        mul_b = $signed(B_W'(up_reg));
        case (state_reg)
            S_CHAIN:  mul_b = $signed(B_W'((downs_reg != '0) ? dn_reg : up_reg));
            S_SD_MUL: mul_b = $signed(B_W'(dn_reg));
            S_A_MUL:  mul_b = B_W'(delta_reg);
            S_B_MUL: begin
                mul_a = $signed({2'b00, sd_reg});
                mul_b = B_W'(delta_reg);
            end
            S_T_MUL: begin
                mul_a = bq_reg;
                mul_b = $signed(B_W'(disc_reg));
            end
            default: ;
        endcase

        // Memory access
        rd_addr = (state_reg == S_RD_VD) ? i_reg + 1'b1 : i_reg;
        wr_en   = (state_reg == S_LEAF_WR) || (state_reg == S_T_TAKE);
        wr_data = (state_reg == S_LEAF_WR) ? payoff : node_val;

        div_start = (state_reg == S_DIV) && (su_reg > sd_reg);
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Result word taken; S_OUT handles its own refill
            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        s0_reg    <= s_tdata[PW-1:0];
                        k_reg     <= s_tdata[2*PW-1:PW];
                        put_reg   <= s_tuser[0];
                        up_reg    <= UNIT + FAC_W'(v_eff);
                        dn_reg    <= UNIT - FAC_W'(v_eff);
                        disc_reg  <= disc_cfg_reg;
                        n_reg     <= n_eff;
                        i_reg     <= '0;
                        clamp_reg <= 1'b0;
                        delta_reg <= '0;
                        state_reg <= S_LEAF_INIT;
                    end
                end
                S_LEAF_INIT: begin
                    x_reg     <= s0_reg;
                    downs_reg <= i_reg;
                    ups_reg   <= n_reg - i_reg;
                    leaf_reg  <= 1'b1;
                    state_reg <= S_CHAIN;
                end
                S_NODE_INIT: begin
                    x_reg     <= s0_reg;
                    downs_reg <= i_reg;
                    ups_reg   <= lvl_reg - 1'b1 - i_reg;
                    leaf_reg  <= 1'b0;
                    state_reg <= S_CHAIN;
                end
                // Node spot: down factors first, then up factors
                S_CHAIN: begin
                    if (downs_reg != '0 || ups_reg != '0) begin
                        state_reg <= S_CHAIN_TAKE;
                    end else begin
                        state_reg <= leaf_reg ? S_LEAF_WR : S_SU_MUL;
                    end
                end
                S_CHAIN_TAKE: begin
                    x_reg     <= scl_val;
                    clamp_reg <= clamp_reg | scl_clamp;
                    if (downs_reg != '0) begin
                        downs_reg <= downs_reg - 1'b1;
                    end else begin
                        ups_reg <= ups_reg - 1'b1;
                    end
                    state_reg <= S_CHAIN;
                end
                S_LEAF_WR: begin
                    last_val_reg <= payoff;
                    if (i_reg == n_reg) begin
                        i_reg     <= '0;
                        lvl_reg   <= n_reg;
                        state_reg <= (n_reg == '0) ? S_OUT : S_NODE_INIT;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_LEAF_INIT;
                    end
                end
                S_SU_MUL: state_reg <= S_SU_TAKE;
                S_SU_TAKE: begin
                    su_reg    <= scl_val;
                    clamp_reg <= clamp_reg | scl_clamp;
                    state_reg <= S_SD_MUL;
                end
                S_SD_MUL: state_reg <= S_SD_TAKE;
                S_SD_TAKE: begin
                    sd_reg    <= scl_val;
                    clamp_reg <= clamp_reg | scl_clamp;
                    state_reg <= S_RD_VU;
                end
                S_RD_VU: state_reg <= S_RD_VD;
                S_RD_VD: begin
                    vu_reg    <= rd_data_reg;
                    state_reg <= S_RD_DONE;
                end
                S_RD_DONE: begin
                    vd_reg    <= rd_data_reg;
                    state_reg <= S_DIV;
                end
                // A spot difference that is not positive gives delta 0
                S_DIV: begin
                    dv_neg_reg <= dv[PW];
                    if (su_reg > sd_reg) begin
                        state_reg <= S_DIV_WAIT;
                    end else begin
                        delta_reg <= '0;
                        state_reg <= S_A_MUL;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        delta_reg <= div_delta;
                        clamp_reg <= clamp_reg | mag_clamp;
                        state_reg <= S_A_MUL;
                    end
                end
                S_A_MUL: state_reg <= S_A_TAKE;
                S_A_TAKE: begin
                    a_reg     <= prod_reg;
                    state_reg <= S_B_MUL;
                end
                S_B_MUL: state_reg <= S_B_TAKE;
                S_B_TAKE: begin
                    bq_reg    <= A_W'(b_full >>> FRAC_BITS);
                    state_reg <= S_T_MUL;
                end
                S_T_MUL: state_reg <= S_T_TAKE;
                S_T_TAKE: begin
                    last_val_reg <= node_val;
                    clamp_reg    <= clamp_reg | node_clamp;
                    if (i_reg == lvl_reg - 1'b1) begin
                        i_reg     <= '0;
                        lvl_reg   <= lvl_reg - 1'b1;
                        state_reg <= (lvl_reg == IDX_W'(1)) ? S_OUT : S_NODE_INIT;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_NODE_INIT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_val_reg   <= last_val_reg;
                        m_delta_reg <= bop_pkg::DELTA_W'(delta_reg);
                        m_sat_reg   <= clamp_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = bop_pkg::M_DATA_W'({m_delta_reg, m_val_reg});
    assign m_tuser  = m_sat_reg;

endmodule

FILE: design/bop_chk.sv
// Port-level checker for the binomial option pricer, bound to the top level.
`include "binomial_option_pricer_macros.svh"

module bop_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bop_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser
);

    // A stalled result word holds
    `BOP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Delta stays within plus or minus one unit
    `BOP_ASSERT_NOW(a_delta_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[49:32]) <= 18'sd65536) && ($signed(m_tdata[49:32]) >= -18'sd65536))

    // A taken request keeps the block busy
    `BOP_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A new result only comes out of a busy period
    `BOP_ASSERT_NOW(a_result_after_work, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))

endmodule

bind binomial_option_pricer bop_chk u_bop_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
